[sv/akt_pkg.sv]
// Shared types and constants of the aged key table.
// Payload structs for the command and response channels and the commit write,
// the scan token that walks the cell chain, and the flag and status codes.
package akt_pkg;

    localparam int AGE_W     = 4;
    localparam int VALUE_W   = 32;
    localparam int ATTR_W    = 16;
    localparam int OWNER_W   = 4;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 5;
    localparam int LIVE_W    = 6;
    localparam int VERSION_W = 32;

    typedef logic [AGE_W-1:0]    akt_age_t;
    typedef logic [1:0]          akt_flag_t;
    typedef logic [STATUS_W-1:0] akt_status_t;

    localparam akt_age_t AGE_MAX         = 4'd15;
    localparam akt_age_t AGE_LIMIT_RESET = 4'd3;

    // Entry flags.
    localparam akt_flag_t FLAG_FREE     = 2'd0;
    localparam akt_flag_t FLAG_USED     = 2'd1;
    localparam akt_flag_t FLAG_DELETING = 2'd2;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Result status codes.
    localparam akt_status_t ST_INSERTED  = 3'd0;
    localparam akt_status_t ST_DUPLICATE = 3'd1;
    localparam akt_status_t ST_FULL      = 3'd2;
    localparam akt_status_t ST_DELETED   = 3'd3;
    localparam akt_status_t ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] key_value;
        logic [ATTR_W-1:0]  key_attr;
        logic [OWNER_W-1:0] owner_id;
    } akt_cmd_t;

    typedef struct packed {
        akt_status_t          status;
        logic [SLOT_W-1:0]    slot;
        logic [LIVE_W-1:0]    live_count;
        logic [VERSION_W-1:0] version;
    } akt_rsp_t;

    // Token that travels one cell per cycle and collects the scan result.
    typedef struct packed {
        logic               active;
        logic               operation;
        logic [VALUE_W-1:0] key_value;
        logic [ATTR_W-1:0]  key_attr;
        logic               hit;
        logic               have_free;
        logic               have_old;
        akt_age_t           best_age;
    } akt_scan_t;

    // Write of a new entry, broadcast to all cells after the scan.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] key_value;
        logic [ATTR_W-1:0]  key_attr;
        logic [OWNER_W-1:0] owner_id;
    } akt_commit_t;

endpackage

[sv/akt_stream_if.sv]
// Valid/ready channel used for the command, response and configuration ports.
// The payload type is a parameter; the structs come from akt_pkg.
interface akt_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

[sv/akt_cell.sv]
// One table entry of the aged key table and its stage of the scan chain.
// Uses akt_pkg for the scan token, commit struct and entry codes.
module akt_cell #(
    parameter int  TABLE_DEPTH = 32,
    parameter int  CELL_INDEX  = 0,
    localparam int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  akt_pkg::akt_age_t    age_limit,
    input  akt_pkg::akt_scan_t   scan_in,
    input  logic [IDX_W-1:0]     first_idx_in,
    input  logic [IDX_W-1:0]     old_idx_in,
    output akt_pkg::akt_scan_t   scan_out,
    output logic [IDX_W-1:0]     first_idx_out,
    output logic [IDX_W-1:0]     old_idx_out,
    input  akt_pkg::akt_commit_t commit,
    input  logic [IDX_W-1:0]     commit_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    akt_pkg::akt_flag_t                 flag_reg, flag_next;
    akt_pkg::akt_age_t                  age_reg, age_next;
    logic [akt_pkg::VALUE_W-1:0]        value_reg, value_next;
    logic [akt_pkg::ATTR_W-1:0]         attr_reg, attr_next;
    logic [akt_pkg::OWNER_W-1:0]        owner_reg, owner_next;
    akt_pkg::akt_scan_t                 scan_reg, scan_next;
    logic [IDX_W-1:0]                   first_idx_reg, first_idx_next;
    logic [IDX_W-1:0]                   old_idx_reg, old_idx_next;
    logic                               key_match;
    akt_pkg::akt_age_t                  age_inc;

    assign key_match = (value_reg == scan_in.key_value) && (attr_reg == scan_in.key_attr);
    assign age_inc   = (age_reg == akt_pkg::AGE_MAX) ? akt_pkg::AGE_MAX
                                                     : age_reg + akt_pkg::akt_age_t'(1);

    always_comb
    begin
        flag_next      = flag_reg;
        age_next       = age_reg;
        value_next     = value_reg;
        attr_next      = attr_reg;
        owner_next     = owner_reg;
        scan_next      = scan_in;
        first_idx_next = first_idx_in;
        old_idx_next   = old_idx_in;

        if (commit.valid && (commit_idx == MY_IDX))
        begin
            // The entry keeps its old age; delete always clears it anyway.
            flag_next  = akt_pkg::FLAG_USED;
            value_next = commit.key_value;
            attr_next  = commit.key_attr;
            owner_next = commit.owner_id;
        end
        else if (scan_in.active)
        begin
            if (scan_in.operation == akt_pkg::OP_DELETE)
            begin
                if (!scan_in.hit && (flag_reg == akt_pkg::FLAG_USED) && key_match)
                begin
                    flag_next      = akt_pkg::FLAG_DELETING;
                    age_next       = '0;
                    scan_next.hit  = 1'b1;
                    first_idx_next = MY_IDX;
                end
            end
            else
            begin
                unique case (flag_reg)
                    akt_pkg::FLAG_FREE:
                    begin
                        if (!scan_in.have_free)
                        begin
                            scan_next.have_free = 1'b1;
                            first_idx_next      = MY_IDX;
                        end
                    end
                    akt_pkg::FLAG_USED:
                    begin
                        if (key_match)
                        begin
                            scan_next.hit = 1'b1;
                        end
                    end
                    akt_pkg::FLAG_DELETING:
                    begin
                        age_next = age_inc;
                        if (age_inc >= age_limit)
                        begin
                            flag_next = akt_pkg::FLAG_FREE;
                        end
                        // Strictly greater keeps the first entry seen at the top age.
                        if (age_inc > scan_in.best_age)
                        begin
                            scan_next.best_age = age_inc;
                            scan_next.have_old = 1'b1;
                            old_idx_next       = MY_IDX;
                        end
                    end
                    default:
                    begin
                        flag_next = flag_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= akt_pkg::FLAG_FREE;
            age_reg  <= '0;
            scan_reg <= '0;
        end
        else
        begin
            flag_reg <= flag_next;
            age_reg  <= age_next;
            scan_reg <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        attr_reg      <= attr_next;
        owner_reg     <= owner_next;
        first_idx_reg <= first_idx_next;
        old_idx_reg   <= old_idx_next;
    end

    assign scan_out      = scan_reg;
    assign first_idx_out = first_idx_reg;
    assign old_idx_out   = old_idx_reg;

endmodule

[sv/aged_key_table_insert_delete.sv]
// Top level of the aged key table: command, response and configuration
// channels, result logic and the chain of akt_cell entries.
// Depends on akt_pkg, akt_stream_if and akt_cell.
//
// The table holds TABLE_DEPTH keyed entries, one per cell of a chain. Each
// command (insert or delete) is one transfer on cmd and yields exactly one
// transfer on rsp. The command travels down the chain as a token, one cell
// per cycle; every cell checks and updates its own entry as the token passes
// (delete marks the first in-use match as deleting, insert ages deleting
// entries, notes the first free one, the oldest deleting one and any
// duplicate). After the last cell, the result is formed and, for a
// successful insert, the chosen entry is written through the commit
// register once the result is loaded. A command passes through a launch,
// the chain traversal, a capture and a result step. Commands are handled
// one at a time; cmd.ready is high while no command is in flight, even if
// the previous response still waits on rsp. age_limit is written over cfg,
// which never stalls, and should only be written while the block is idle.
// All entry flags clear at reset, so no clearing pass is needed after reset.
module aged_key_table_insert_delete #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    akt_stream_if.sink   cmd,
    akt_stream_if.source rsp,
    akt_stream_if.sink   cfg
);

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_EXT_W = (IDX_W > akt_pkg::SLOT_W) ? IDX_W : akt_pkg::SLOT_W;
    localparam int CNT_EXT_W  = (CNT_W > akt_pkg::LIVE_W) ? CNT_W : akt_pkg::LIVE_W;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                      state_reg, state_next;
    akt_pkg::akt_cmd_t               cmd_reg, cmd_next;
    akt_pkg::akt_scan_t              launch_reg, launch_next;
    akt_pkg::akt_scan_t              fin_reg, fin_next;
    logic [IDX_W-1:0]                fin_first_reg, fin_first_next;
    logic [IDX_W-1:0]                fin_old_reg, fin_old_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [akt_pkg::VERSION_W-1:0]   version_reg, version_next;
    akt_pkg::akt_age_t               limit_reg, limit_next;
    akt_pkg::akt_rsp_t               rsp_reg, rsp_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    akt_pkg::akt_commit_t            commit_reg, commit_next;
    logic [IDX_W-1:0]                commit_idx_reg, commit_idx_next;

    akt_pkg::akt_status_t            res_status;
    logic [IDX_W-1:0]                res_idx;
    logic                            res_write;
    logic                            done_fire;
    logic [SLOT_EXT_W-1:0]           slot_ext;
    logic [CNT_EXT_W-1:0]            count_ext;

    akt_pkg::akt_scan_t              chain_scan  [TABLE_DEPTH+1];
    logic [IDX_W-1:0]                chain_first [TABLE_DEPTH+1];
    logic [IDX_W-1:0]                chain_old   [TABLE_DEPTH+1];

    // The token enters the chain from the launch register.
    assign chain_scan[0]  = launch_reg;
    assign chain_first[0] = '0;
    assign chain_old[0]   = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        akt_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .CELL_INDEX  (g)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .age_limit     (limit_reg),
            .scan_in       (chain_scan[g]),
            .first_idx_in  (chain_first[g]),
            .old_idx_in    (chain_old[g]),
            .scan_out      (chain_scan[g+1]),
            .first_idx_out (chain_first[g+1]),
            .old_idx_out   (chain_old[g+1]),
            .commit        (commit_reg),
            .commit_idx    (commit_idx_reg)
        );
    end

    // Decode of the finished scan. A reused deleting entry is written even
    // if the same scan just freed it.
    always_comb
    begin
        res_status = akt_pkg::ST_NOT_FOUND;
        res_idx    = '0;
        res_write  = 1'b0;
        if (fin_reg.operation == akt_pkg::OP_DELETE)
        begin
            if (fin_reg.hit)
            begin
                res_status = akt_pkg::ST_DELETED;
                res_idx    = fin_first_reg;
            end
        end
        else if (fin_reg.hit)
        begin
            res_status = akt_pkg::ST_DUPLICATE;
        end
        else if (fin_reg.have_free)
        begin
            res_status = akt_pkg::ST_INSERTED;
            res_idx    = fin_first_reg;
            res_write  = 1'b1;
        end
        else if (fin_reg.have_old)
        begin
            res_status = akt_pkg::ST_INSERTED;
            res_idx    = fin_old_reg;
            res_write  = 1'b1;
        end
        else
        begin
            res_status = akt_pkg::ST_FULL;
        end
    end

    // The result is loaded once the response register is free.
    assign done_fire = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        launch_next     = '0;
        fin_next        = fin_reg;
        fin_first_next  = fin_first_reg;
        fin_old_next    = fin_old_reg;
        count_next      = count_reg;
        version_next    = version_reg;
        limit_next      = limit_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        commit_next     = '0;
        commit_idx_next = commit_idx_reg;
        slot_ext        = '0;
        count_ext       = '0;

        if (cfg.valid)
        begin
            limit_next = cfg.payload;
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next              = cmd.payload;
                    launch_next.active    = 1'b1;
                    launch_next.operation = cmd.payload.operation;
                    launch_next.key_value = cmd.payload.key_value;
                    launch_next.key_attr  = cmd.payload.key_attr;
                    state_next            = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // The token leaves the last cell for exactly one cycle.
                if (chain_scan[TABLE_DEPTH].active)
                begin
                    fin_next       = chain_scan[TABLE_DEPTH];
                    fin_first_next = chain_first[TABLE_DEPTH];
                    fin_old_next   = chain_old[TABLE_DEPTH];
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (done_fire)
                begin
                    if (res_status == akt_pkg::ST_DELETED)
                    begin
                        count_next   = count_reg - CNT_W'(1);
                        version_next = version_reg + akt_pkg::VERSION_W'(1);
                    end
                    if (res_write)
                    begin
                        count_next            = count_reg + CNT_W'(1);
                        version_next          = version_reg + akt_pkg::VERSION_W'(1);
                        commit_next.valid     = 1'b1;
                        commit_next.key_value = cmd_reg.key_value;
                        commit_next.key_attr  = cmd_reg.key_attr;
                        commit_next.owner_id  = cmd_reg.owner_id;
                        commit_idx_next       = res_idx;
                    end
                    slot_ext            = SLOT_EXT_W'(res_idx);
                    count_ext           = CNT_EXT_W'(count_next);
                    rsp_next.status     = res_status;
                    rsp_next.slot       = slot_ext[akt_pkg::SLOT_W-1:0];
                    rsp_next.live_count = count_ext[akt_pkg::LIVE_W-1:0];
                    rsp_next.version    = version_next;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= '0;
            count_reg     <= '0;
            version_reg   <= '0;
            limit_reg     <= akt_pkg::AGE_LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
            commit_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            count_reg     <= count_next;
            version_reg   <= version_next;
            limit_reg     <= limit_next;
            rsp_valid_reg <= rsp_valid_next;
            commit_reg    <= commit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        fin_reg        <= fin_next;
        fin_first_reg  <= fin_first_next;
        fin_old_reg    <= fin_old_next;
        rsp_reg        <= rsp_next;
        commit_idx_reg <= commit_idx_next;
    end

    assign cmd.ready   = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // The live count can never exceed the number of entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("live count exceeds table depth");

    // A launched token leaves the last cell after passing every cell of the chain.
    a_chain_latency: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg.active |-> ##TABLE_DEPTH chain_scan[TABLE_DEPTH].active)
        else $error("scan token lost in the cell chain");

    // Counters only move when a result is loaded.
    a_version_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !done_fire |=> $stable(version_reg) && $stable(count_reg))
        else $error("table counters changed outside result cycle");

    // An entry write always belongs to an inserted result that is on rsp.
    a_commit_inserted: assert property (@(posedge clk) disable iff (!rst_n)
        commit_reg.valid |-> rsp_valid_reg && (rsp_reg.status == akt_pkg::ST_INSERTED))
        else $error("entry written without an inserted result");

    // A launched token must find the sequencer in the scan state.
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg.active |-> (state_reg == S_SCAN) && !fin_reg.active || (state_reg == S_SCAN))
        else $error("token launched outside a scan");

endmodule
